@@ design/lbrc_pkg.sv @@
// ----------------------------------------------------------------------------
// lbrc_pkg: shared types, constants and gamma table functions
// payload structs, mode and register codes, reset values, gamma rom builder
// ----------------------------------------------------------------------------
package lbrc_pkg;

	// field widths
	localparam int LEVEL_W  = 16;
	localparam int CUR_W    = 16;
	localparam int STROBE_W = 7;
	localparam int SLOT_W   = 4;
	localparam int DATA_W   = 16;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

	// parameter defaults
	localparam int DEF_SLOTS          = 13;
	localparam int DEF_GAMMA_X100     = 220;
	localparam int DEF_GAMMA_ROM_BITS = 10;

	// register reset values
	localparam logic [15:0] RST_STEP_SIZE     = 16'd655;
	localparam logic [6:0]  RST_STROBE_TICKS  = 7'd50;
	localparam logic [15:0] RST_CURRENT_LOW   = 16'd0;
	localparam logic [15:0] RST_CURRENT_HIGH  = 16'd65535;
	localparam logic [15:0] RST_MIN_CURRENT   = 16'd0;
	localparam logic        RST_NOTE_LED      = 1'b1;
	localparam logic [15:0] RST_DEFAULT_LEVEL = 16'd32768;
	localparam logic        RST_REMEMBER      = 1'b1;

	// input item modes
	typedef enum logic [1:0] {
		MODE_TICK   = 2'd0,
		MODE_CLEAR  = 2'd1,
		MODE_REDIR  = 2'd2,
		MODE_BRESET = 2'd3
	} lbrc_mode_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_STEP_SIZE     = 3'd0,
		CFG_STROBE_TICKS  = 3'd1,
		CFG_CURRENT_LOW   = 3'd2,
		CFG_CURRENT_HIGH  = 3'd3,
		CFG_MIN_CURRENT   = 3'd4,
		CFG_NOTE_LED      = 3'd5,
		CFG_DEFAULT_LEVEL = 3'd6,
		CFG_REMEMBER      = 3'd7
	} lbrc_cfg_idx_t;

	typedef struct packed {
		lbrc_mode_t        mode;
		logic [SLOT_W-1:0] slot;
		logic              locked;
		logic              key_pressed;
		logic              low_voltage;
		logic              force_reset;
	} lbrc_item_t;

	typedef struct packed {
		logic [CUR_W-1:0]   drive_current;
		logic               flash_on;
		logic               adjusting;
		logic               show_direction;
		logic               direction_down;
		logic [LEVEL_W-1:0] level;
	} lbrc_result_t;

	typedef struct packed {
		logic [15:0]         step_size;
		logic [STROBE_W-1:0] strobe_ticks;
		logic [CUR_W-1:0]    current_low;
		logic [CUR_W-1:0]    current_high;
		logic [CUR_W-1:0]    min_current;
		logic                note_led_enable;
		logic [LEVEL_W-1:0]  default_level;
		logic                remember_enable;
	} lbrc_cfg_regs_t;

	// classified operation held in the queue
	typedef struct packed {
		lbrc_mode_t mode;
		logic       locked;
		logic       key_pressed;
		logic       low_voltage;
		logic       force_reset;
	} lbrc_op_t;

	// ramp unit outcome handed to the current path
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               direction_down;
		logic               flash_on;
		logic               adjusting;
		logic               show_direction;
		logic               drive_zero;
	} lbrc_ramp_t;

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] LN2_Q30 = 64'd744261118;

	// q30 base-two logarithm, elaboration only
	function automatic logic [63:0] log2_q30(input logic [31:0] v);
		logic [5:0]  n;
		logic [63:0] m;
		logic [63:0] r;
		n = 6'd0;
		for (int k = 0; k < 30; k++) begin
			if ((v >> (k + 1)) != 32'd0) n = 6'(k + 1);
		end
		m = {32'd0, v} << (6'd30 - n);
		r = {58'd0, n} << 30;
		for (int b = 29; b >= 0; b--) begin
			m = (m * m) >> 30;
			if (m >= (Q30_ONE << 1)) begin
				m = m >> 1;
				r[b] = 1'b1;
			end
		end
		return r;
	endfunction

	// q30 two to the minus e, series for the fraction
	function automatic logic [63:0] exp2_neg_q30(input logic [63:0] e);
		logic [63:0] k;
		logic [63:0] y;
		logic [63:0] term;
		longint      sum;
		k    = e >> 30;
		y    = ((e & (Q30_ONE - 64'd1)) * LN2_Q30) >> 30;
		term = Q30_ONE;
		sum  = longint'(Q30_ONE);
		for (int n = 1; n <= 20; n++) begin
			term = ((term * y) >> 30) / 64'(n);
			if (n % 2 == 1) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		if (k >= 64'd40) return 64'd0;
		return 64'(sum) >> k;
	endfunction

	// one gamma table entry
	function automatic logic [15:0] gamma_entry(input logic [31:0] i, input int rom_bits,
			input int gx100);
		logic [31:0] top;
		logic [63:0] lt;
		logic [63:0] li;
		logic [63:0] d;
		logic [63:0] v;
		logic [63:0] r;
		if (i == 32'd0) return 16'd0;
		top = (32'd1 << rom_bits) - 32'd1;
		lt  = log2_q30(top);
		li  = log2_q30(i);
		d   = (lt > li) ? lt - li : 64'd0;
		v   = exp2_neg_q30(d * 64'(gx100) / 64'd100);
		r   = (v * 64'd65535 + (64'd1 << 29)) >> 30;
		return (r > 64'd65535) ? 16'hFFFF : r[15:0];
	endfunction

endpackage

@@ design/led_brightness_ramp_controller.sv @@
// ----------------------------------------------------------------------------
// led_brightness_ramp_controller: stepless led dimming ramp
// per-slot levels and directions, limit blanking and gamma-mapped drive current
// ----------------------------------------------------------------------------
// Takes one item per clock, sustained while the queue has room. The rate
// is set by the ramp unit, which reads, updates and writes back the
// selected slot's level, direction and the shared blanking state as it
// takes each beat from the queue; the gamma rom read, the multiply
// and the rounded divide follow in their own pipeline stages. A two-entry
// queue sits between intake and the ramp unit, and a stalled result holds
// the whole back pipeline while the queue takes beats until it is full.
// Configuration registers are read as each beat leaves the queue, so the user
// must see they are written only while no beat is in flight; not enforced here.
module led_brightness_ramp_controller #(
	parameter int SLOTS          = lbrc_pkg::DEF_SLOTS,
	parameter int GAMMA_X100     = lbrc_pkg::DEF_GAMMA_X100,
	parameter int GAMMA_ROM_BITS = lbrc_pkg::DEF_GAMMA_ROM_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  lbrc_pkg::lbrc_cfg_idx_t    cfg_index,
	input  logic [lbrc_pkg::DATA_W-1:0] cfg_wdata,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  lbrc_pkg::lbrc_item_t       item,
	output logic                       result_valid,
	input  logic                       result_stall,
	output lbrc_pkg::lbrc_result_t     result
);
	import lbrc_pkg::*;

	localparam int IDX_W = $clog2(SLOTS + 1);

	lbrc_cfg_regs_t   cfg_q;
	logic             op_valid;
	lbrc_op_t         op;
	logic [IDX_W-1:0] op_idx;
	logic             pop;
	logic             advance;
	lbrc_ramp_t       ramp;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_size       <= RST_STEP_SIZE;
			cfg_q.strobe_ticks    <= RST_STROBE_TICKS;
			cfg_q.current_low     <= RST_CURRENT_LOW;
			cfg_q.current_high    <= RST_CURRENT_HIGH;
			cfg_q.min_current     <= RST_MIN_CURRENT;
			cfg_q.note_led_enable <= RST_NOTE_LED;
			cfg_q.default_level   <= RST_DEFAULT_LEVEL;
			cfg_q.remember_enable <= RST_REMEMBER;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STEP_SIZE:     cfg_q.step_size       <= cfg_wdata;
				CFG_STROBE_TICKS:  cfg_q.strobe_ticks    <= cfg_wdata[STROBE_W-1:0];
				CFG_CURRENT_LOW:   cfg_q.current_low     <= cfg_wdata;
				CFG_CURRENT_HIGH:  cfg_q.current_high    <= cfg_wdata;
				CFG_MIN_CURRENT:   cfg_q.min_current     <= cfg_wdata;
				CFG_NOTE_LED:      cfg_q.note_led_enable <= cfg_wdata[0];
				CFG_DEFAULT_LEVEL: cfg_q.default_level   <= cfg_wdata;
				CFG_REMEMBER:      cfg_q.remember_enable <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// intake and queue
	lbrc_front #(
		.SLOTS(SLOTS),
		.IDX_W(IDX_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.pop       (pop),
		.op_valid  (op_valid),
		.op        (op),
		.op_idx    (op_idx)
	);

	// slot state update
	lbrc_ramp #(
		.SLOTS(SLOTS),
		.IDX_W(IDX_W)
	) u_ramp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.op_valid(op_valid),
		.op      (op),
		.op_idx  (op_idx),
		.advance (advance),
		.pop     (pop),
		.ramp    (ramp)
	);

	// drive current pipeline and result register
	lbrc_drive #(
		.GAMMA_X100    (GAMMA_X100),
		.GAMMA_ROM_BITS(GAMMA_ROM_BITS)
	) u_drive (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.ramp_valid  (pop),
		.ramp        (ramp),
		.advance     (advance),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

@@ design/lbrc_front.sv @@
// ----------------------------------------------------------------------------
// lbrc_front: item intake and slot classification
// resolves the slot index and queues the operation for the ramp unit
// ----------------------------------------------------------------------------
module lbrc_front #(
	parameter int SLOTS = lbrc_pkg::DEF_SLOTS,
	parameter int IDX_W = $clog2(SLOTS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  lbrc_pkg::lbrc_item_t item,
	input  logic                pop,
	output logic                op_valid,
	output lbrc_pkg::lbrc_op_t  op,
	output logic [IDX_W-1:0]    op_idx
);
	import lbrc_pkg::*;

	localparam int QDEPTH = 2;

	lbrc_op_t         op_mem_q  [QDEPTH];
	logic [IDX_W-1:0] idx_mem_q [QDEPTH];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic [IDX_W-1:0] idx_new;
	lbrc_op_t         op_new;

	// emergency slot while locked, out of range slots fall back to slot 0
	always_comb begin
		if (item.locked) idx_new = IDX_W'(SLOTS);
		else if (int'(item.slot) < SLOTS) idx_new = IDX_W'(item.slot);
		else idx_new = '0;
		op_new.mode        = item.mode;
		op_new.locked      = item.locked;
		op_new.key_pressed = item.key_pressed;
		op_new.low_voltage = item.low_voltage;
		op_new.force_reset = item.force_reset;
	end

	assign item_stall = (count_q == 2'(QDEPTH));
	assign push       = item_valid && !item_stall;
	assign op_valid   = (count_q != 2'd0);
	assign op         = op_mem_q[rd_ptr_q];
	assign op_idx     = idx_mem_q[rd_ptr_q];

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			op_mem_q[wr_ptr_q]  <= op_new;
			idx_mem_q[wr_ptr_q] <= idx_new;
		end
	end

endmodule

@@ design/lbrc_ramp.sv @@
// ----------------------------------------------------------------------------
// lbrc_ramp: per-slot ramp state and blanking control
// one read-modify-write of the selected slot for each beat taken from the queue
// ----------------------------------------------------------------------------
module lbrc_ramp #(
	parameter int SLOTS = lbrc_pkg::DEF_SLOTS,
	parameter int IDX_W = $clog2(SLOTS + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lbrc_pkg::lbrc_cfg_regs_t cfg,
	input  logic                    op_valid,
	input  lbrc_pkg::lbrc_op_t      op,
	input  logic [IDX_W-1:0]        op_idx,
	input  logic                    advance,
	output logic                    pop,
	output lbrc_pkg::lbrc_ramp_t    ramp
);
	import lbrc_pkg::*;

	logic [LEVEL_W-1:0]  level_q [SLOTS+1];
	logic                dir_q   [SLOTS+1];
	logic                key_held_q;
	logic                armed_q;
	logic [STROBE_W-1:0] blank_q;
	logic                lit_q;

	logic [LEVEL_W-1:0]  lvl_cur;
	logic                dir_cur;
	logic [LEVEL_W:0]    sum_up;
	logic [LEVEL_W-1:0]  lvl_up;
	logic [LEVEL_W-1:0]  lvl_down;
	logic [LEVEL_W-1:0]  lvl_d;
	logic                dir_d;
	logic                key_d;
	logic                arm_d;
	logic [STROBE_W-1:0] blank_d;
	logic                lit_d;
	logic                adj;

	assign pop     = op_valid && advance;
	assign lvl_cur = level_q[op_idx];
	assign dir_cur = dir_q[op_idx];

	// saturating step in both directions
	assign sum_up   = {1'b0, lvl_cur} + {1'b0, cfg.step_size};
	assign lvl_up   = sum_up[LEVEL_W] ? LEVEL_MAX : sum_up[LEVEL_W-1:0];
	assign lvl_down = (lvl_cur > cfg.step_size) ? lvl_cur - cfg.step_size : '0;

	// next state for the selected slot
	always_comb begin
		lvl_d   = lvl_cur;
		dir_d   = dir_cur;
		key_d   = key_held_q;
		arm_d   = armed_q;
		blank_d = blank_q;
		lit_d   = lit_q;
		adj     = 1'b0;
		unique case (op.mode)
			MODE_TICK: begin
				if (op.key_pressed != key_held_q) begin
					key_d = op.key_pressed;
					if (!op.key_pressed) dir_d = ~dir_cur;
					else arm_d = 1'b1;
				end
				if (key_d) begin
					lvl_d = dir_d ? lvl_down : lvl_up;
					adj   = cfg.note_led_enable && (lvl_d != '0) && (lvl_d != LEVEL_MAX);
				end
				if (arm_d && ((lvl_d == '0) || (lvl_d == LEVEL_MAX))) begin
					arm_d   = 1'b0;
					lit_d   = 1'b0;
					blank_d = cfg.strobe_ticks;
				end
				if (blank_d != '0) blank_d = blank_d - STROBE_W'(1);
				else if (!op.low_voltage) lit_d = 1'b1;
			end
			MODE_CLEAR: begin
				key_d   = 1'b0;
				arm_d   = 1'b0;
				blank_d = '0;
				lit_d   = 1'b1;
			end
			MODE_REDIR: begin
				if (lvl_cur == LEVEL_MAX) dir_d = 1'b1;
				if (lvl_cur == '0) dir_d = 1'b0;
			end
			MODE_BRESET: begin
				if (op.locked) begin
					arm_d = 1'b0;
					lvl_d = '0;
					dir_d = 1'b0;
				end else if (op.force_reset || !cfg.remember_enable) begin
					lvl_d = cfg.default_level;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		ramp.level          = lvl_d;
		ramp.direction_down = dir_d;
		ramp.flash_on       = lit_d;
		ramp.adjusting      = adj;
		ramp.show_direction = adj && !op.locked;
		ramp.drive_zero     = (op.mode == MODE_CLEAR);
	end

	// slot stores and shared ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= SLOTS; s++) begin
				level_q[s] <= '0;
				dir_q[s]   <= 1'b0;
			end
			key_held_q <= 1'b0;
			armed_q    <= 1'b0;
			blank_q    <= '0;
			lit_q      <= 1'b1;
		end else if (pop) begin
			level_q[op_idx] <= lvl_d;
			dir_q[op_idx]   <= dir_d;
			key_held_q      <= key_d;
			armed_q         <= arm_d;
			blank_q         <= blank_d;
			lit_q           <= lit_d;
		end
	end

endmodule

@@ design/lbrc_drive.sv @@
// ----------------------------------------------------------------------------
// lbrc_drive: gamma lookup and drive current arithmetic
// rom read, signed multiply, rounded divide by full scale, output register
// ----------------------------------------------------------------------------
module lbrc_drive #(
	parameter int GAMMA_X100     = lbrc_pkg::DEF_GAMMA_X100,
	parameter int GAMMA_ROM_BITS = lbrc_pkg::DEF_GAMMA_ROM_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lbrc_pkg::lbrc_cfg_regs_t cfg,
	input  logic                    ramp_valid,
	input  lbrc_pkg::lbrc_ramp_t    ramp,
	output logic                    advance,
	output logic                    result_valid,
	input  logic                    result_stall,
	output lbrc_pkg::lbrc_result_t  result
);
	import lbrc_pkg::*;

	localparam int ROM_SIZE = 1 << GAMMA_ROM_BITS;
	localparam logic [16:0] FULL   = 17'd65535;
	localparam logic [16:0] FULL_2 = 17'd131070;

	logic [15:0] rom_tab [ROM_SIZE];

	// gamma table built at elaboration
	for (genvar g = 0; g < ROM_SIZE; g++) begin : g_rom
		localparam logic [15:0] ENTRY = gamma_entry(32'(g), GAMMA_ROM_BITS, GAMMA_X100);
		assign rom_tab[g] = ENTRY;
	end

	logic               v_s1;
	lbrc_ramp_t         ramp_s1;
	logic [15:0]        rom_s1;
	logic [CUR_W-1:0]   base_s1;
	logic signed [16:0] diff_s1;

	logic               v_s2;
	lbrc_ramp_t         ramp_s2;
	logic [CUR_W-1:0]   base_s2;
	logic signed [33:0] prod_s2;

	logic               valid_q;
	lbrc_result_t       result_q;

	logic [33:0]        mag;
	logic [31:0]        biased;
	logic [16:0]        rem;
	logic [16:0]        quot;
	logic signed [18:0] total;
	logic [CUR_W-1:0]   drive;

	assign advance      = !(valid_q && result_stall);
	assign result_valid = valid_q;
	assign result       = result_q;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			valid_q <= 1'b0;
		end else if (advance) begin
			v_s1    <= ramp_valid;
			v_s2    <= v_s1;
			valid_q <= v_s2;
		end
	end

	// stage 1: rom read, base and span of the current range
	always_ff @(posedge clk) begin
		if (advance) begin
			ramp_s1 <= ramp;
			rom_s1  <= rom_tab[ramp.level[LEVEL_W-1 -: GAMMA_ROM_BITS]];
			base_s1 <= (cfg.current_low < cfg.min_current) ? cfg.min_current : cfg.current_low;
			diff_s1 <= $signed({1'b0, cfg.current_high}) - $signed({1'b0, cfg.current_low});
		end
	end

	// stage 2: span times gamma
	always_ff @(posedge clk) begin
		if (advance) begin
			ramp_s2 <= ramp_s1;
			base_s2 <= base_s1;
			prod_s2 <= 34'(diff_s1 * $signed({1'b0, rom_s1}));
		end
	end

	// rounded divide by full scale via high half plus remainder correction
	always_comb begin
		mag    = prod_s2[33] ? 34'(-prod_s2) : prod_s2;
		biased = mag[31:0] + 32'd32767;
		rem    = {1'b0, biased[15:0]} + {1'b0, biased[31:16]};
		quot   = {1'b0, biased[31:16]};
		if (rem >= FULL_2) quot = quot + 17'd2;
		else if (rem >= FULL) quot = quot + 17'd1;
		total = prod_s2[33] ? $signed({3'b0, base_s2}) - $signed({2'b0, quot})
			: $signed({3'b0, base_s2}) + $signed({2'b0, quot});
		if (total < 0) drive = '0;
		else if (total > $signed(19'd65535)) drive = '1;
		else drive = total[CUR_W-1:0];
	end

	// stage 3: output register
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.drive_current  <= ramp_s2.drive_zero ? '0 : drive;
			result_q.flash_on       <= ramp_s2.flash_on;
			result_q.adjusting      <= ramp_s2.adjusting;
			result_q.show_direction <= ramp_s2.show_direction;
			result_q.direction_down <= ramp_s2.direction_down;
			result_q.level          <= ramp_s2.level;
		end
	end

endmodule

@@ bench/tb_led_brightness_ramp_controller.sv @@
// ----------------------------------------------------------------------------
// tb_led_brightness_ramp_controller: self-checking bench for the dimming ramp
// drives tick, clear, redirect and brightness reset beats under several
// register settings, predicts every output beat from a shadow of the ramp
// state and compares field by field, with random sender bursts, receiver
// stall patterns and one long receiver hold-off to fill the block
// ----------------------------------------------------------------------------
module tb_led_brightness_ramp_controller;
	import lbrc_pkg::*;

	localparam int SLOTS       = DEF_SLOTS;
	localparam int ROM_N       = 1 << DEF_GAMMA_ROM_BITS;
	localparam int ROM_SHIFT   = 16 - DEF_GAMMA_ROM_BITS;
	localparam int HOLD_CYCLES = 80;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_BEATS = 265;
	localparam logic [63:0] Q30     = 64'd1 << 30;
	localparam logic [63:0] LN2_FIX = 64'd744261118;

	typedef enum int {
		STALL_NONE,
		STALL_SPARSE,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_kind_t;

	logic           clk;
	logic           arst_n       = 1'b0;
	logic           cfg_we       = 1'b0;
	lbrc_cfg_idx_t  cfg_index    = CFG_STEP_SIZE;
	logic [DATA_W-1:0] cfg_wdata = '0;
	logic           item_valid   = 1'b0;
	logic           item_stall;
	lbrc_item_t     item         = '0;
	logic           result_valid;
	logic           result_stall = 1'b0;
	lbrc_result_t   result;

	// shadow of the ramp state and registers
	logic [15:0]    lvl_mem [0:SLOTS];
	logic           dir_mem [0:SLOTS];
	logic           key_latched;
	logic           limit_pending;
	logic           led_lit;
	int unsigned    blank_left;
	lbrc_cfg_regs_t cfg;
	logic [15:0]    gamma_tab [0:ROM_N-1];

	lbrc_result_t   due_outputs [$];
	lbrc_result_t   want_out;
	int             errors = 0;

	// sender burst and receiver hold-off control
	int             burst_left = 0;
	bit             gapless = 1'b0;
	int             hold_asks = 0;
	int             hold_served = 0;
	int             hold_left = 0;
	stall_kind_t    stall_kind = STALL_NONE;
	int             stall_left = 0;
	int unsigned    stall_phase = 0;
	int             quiet = 0;

	led_brightness_ramp_controller u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// q30 base-two logarithm for the gamma table
	function automatic logic [63:0] q30_log2(input logic [31:0] v);
		int unsigned n;
		logic [63:0] m;
		logic [63:0] r;
		n = 0;
		while (n < 30 && (v >> (n + 1)) != 0) n++;
		m = {32'd0, v} << (30 - n);
		r = 64'(n) << 30;
		for (int b = 29; b >= 0; b--) begin
			m = (m * m) >> 30;
			if (m >= 2 * Q30) begin
				m = m >> 1;
				r[b] = 1'b1;
			end
		end
		return r;
	endfunction

	// gamma table: level fraction raised to the gamma power, full scale 65535
	initial begin : gamma_build
		logic [63:0] lt;
		logic [63:0] li;
		logic [63:0] d;
		logic [63:0] e;
		logic [63:0] k;
		logic [63:0] y;
		logic [63:0] term;
		logic [63:0] v;
		logic [63:0] r;
		longint      sum;
		lt = q30_log2(ROM_N - 1);
		gamma_tab[0] = '0;
		for (int i = 1; i < ROM_N; i++) begin
			li = q30_log2(i);
			d  = (lt > li) ? lt - li : 64'd0;
			e  = d * 64'(DEF_GAMMA_X100) / 64'd100;
			k  = e >> 30;
			y  = ((e & (Q30 - 64'd1)) * LN2_FIX) >> 30;
			term = Q30;
			sum  = longint'(Q30);
			// series for two to the minus fraction
			for (int n = 1; n <= 20; n++) begin
				term = ((term * y) >> 30) / 64'(n);
				if (n % 2 == 1) sum = sum - longint'(term);
				else sum = sum + longint'(term);
			end
			if (sum < 0) sum = 0;
			v = (k >= 64'd40) ? 64'd0 : 64'(sum) >> k;
			r = (v * 64'd65535 + (64'd1 << 29)) >> 30;
			gamma_tab[i] = (r > 64'd65535) ? 16'hFFFF : r[15:0];
		end
	end

	// drive current for a level: base plus rounded span times gamma, saturated
	function automatic logic [15:0] current_for(input logic [15:0] lv);
		longint lo;
		longint hi;
		longint floor_cur;
		longint g;
		longint prod;
		longint q;
		longint t;
		lo = cfg.current_low;
		hi = cfg.current_high;
		floor_cur = cfg.min_current;
		g = gamma_tab[lv >> ROM_SHIFT];
		prod = (hi - lo) * g;
		q = (prod >= 0) ? (prod + 32767) / 65535 : -((-prod + 32767) / 65535);
		t = ((lo < floor_cur) ? floor_cur : lo) + q;
		if (t < 0) t = 0;
		if (t > 65535) t = 65535;
		return t[15:0];
	endfunction

	// advance the shadow ramp by one beat and return the output it produces
	function automatic lbrc_result_t next_ramp_output(input lbrc_item_t it);
		lbrc_result_t res;
		int unsigned  sel;
		int unsigned  lv;
		logic         adj;
		logic         show;
		sel  = it.locked ? SLOTS : ((it.slot < SLOTS) ? it.slot : 0);
		lv   = lvl_mem[sel];
		adj  = 1'b0;
		show = 1'b0;
		case (it.mode)
			MODE_TICK: begin
				// key edge: release turns the ramp round, press arms the limit blank
				if (it.key_pressed != key_latched) begin
					key_latched = it.key_pressed;
					if (!it.key_pressed) dir_mem[sel] = ~dir_mem[sel];
					else limit_pending = 1'b1;
				end
				if (key_latched) begin
					if (dir_mem[sel]) begin
						lv = (lv > cfg.step_size) ? lv - cfg.step_size : 0;
					end else begin
						lv = lv + cfg.step_size;
						if (lv > 65535) lv = 65535;
					end
					lvl_mem[sel] = lv[15:0];
					adj  = cfg.note_led_enable && lv > 0 && lv < 65535;
					show = adj && !it.locked;
				end
				if (limit_pending && (lv == 0 || lv == 65535)) begin
					limit_pending = 1'b0;
					led_lit = 1'b0;
					blank_left = cfg.strobe_ticks;
				end
				// blanking countdown, low voltage only blocks relighting
				if (blank_left > 0) blank_left--;
				else if (!it.low_voltage) led_lit = 1'b1;
			end
			MODE_CLEAR: begin
				key_latched = 1'b0;
				blank_left = 0;
				limit_pending = 1'b0;
				led_lit = 1'b1;
			end
			MODE_REDIR: begin
				if (lv == 65535) dir_mem[sel] = 1'b1;
				if (lv == 0) dir_mem[sel] = 1'b0;
			end
			MODE_BRESET: begin
				if (it.locked) begin
					limit_pending = 1'b0;
					lv = 0;
					dir_mem[sel] = 1'b0;
				end else if (it.force_reset || !cfg.remember_enable) begin
					lv = cfg.default_level;
				end
				lvl_mem[sel] = lv[15:0];
			end
		endcase
		res.drive_current  = (it.mode == MODE_CLEAR) ? 16'd0 : current_for(lv[15:0]);
		res.flash_on       = led_lit;
		res.adjusting      = adj;
		res.show_direction = show;
		res.direction_down = dir_mem[sel];
		res.level          = lv[15:0];
		return res;
	endfunction

	function automatic lbrc_item_t beat_of(input lbrc_mode_t mode, input int slot,
			input bit locked, input bit key, input bit lowv, input bit force_rst);
		lbrc_item_t it;
		it.mode        = mode;
		it.slot        = 4'(slot);
		it.locked      = locked;
		it.key_pressed = key;
		it.low_voltage = lowv;
		it.force_reset = force_rst;
		return it;
	endfunction

	function automatic lbrc_item_t random_item();
		return beat_of(lbrc_mode_t'($urandom_range(0, 3)), $urandom_range(0, 15),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endfunction

	// offer one beat, with a random gap at the start of each burst
	task automatic send_beat(input lbrc_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (!gapless && gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		due_outputs.push_back(next_ramp_output(it));
	endtask

	// stop offering and wait until every due output has come back
	task automatic settle();
		item_valid <= 1'b0;
		while (due_outputs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write all eight registers back to back while the block is idle
	task automatic load_settings(input lbrc_cfg_regs_t s);
		settle();
		for (int r = 0; r < 8; r++) begin
			cfg_we <= 1'b1;
			cfg_index <= lbrc_cfg_idx_t'(r);
			case (lbrc_cfg_idx_t'(r))
				CFG_STEP_SIZE:     cfg_wdata <= s.step_size;
				CFG_STROBE_TICKS:  cfg_wdata <= {9'd0, s.strobe_ticks};
				CFG_CURRENT_LOW:   cfg_wdata <= s.current_low;
				CFG_CURRENT_HIGH:  cfg_wdata <= s.current_high;
				CFG_MIN_CURRENT:   cfg_wdata <= s.min_current;
				CFG_NOTE_LED:      cfg_wdata <= {15'd0, s.note_led_enable};
				CFG_DEFAULT_LEVEL: cfg_wdata <= s.default_level;
				CFG_REMEMBER:      cfg_wdata <= {15'd0, s.remember_enable};
			endcase
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cfg = s;
	endtask

	// one press-and-release of the key on one slot, with some stray beats
	task automatic send_ramp_session(inout int sent);
		lbrc_item_t it;
		int hold_n;
		int rel_n;
		it = beat_of(MODE_TICK, ($urandom_range(0, 7) == 0) ? $urandom_range(13, 15) :
			$urandom_range(0, 12), $urandom_range(0, 4) == 0, 1'b0, 1'b0,
			1'($urandom_range(0, 1)));
		if ($urandom_range(0, 3) == 0) begin
			it.mode = lbrc_mode_t'($urandom_range(1, 3));
			send_beat(it);
			sent++;
			it.mode = MODE_TICK;
		end
		hold_n = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 160) : $urandom_range(1, 40);
		rel_n  = $urandom_range(1, 6);
		for (int k = 0; k < hold_n + rel_n; k++) begin
			if ($urandom_range(0, 6) == 0) begin
				send_beat(random_item());
			end else begin
				it.key_pressed = (k < hold_n);
				it.low_voltage = ($urandom_range(0, 9) == 0);
				send_beat(it);
			end
			sent++;
		end
	endtask

	// ramp up and down on one slot at reset settings, then the slot special cases
	task automatic test_basics();
		send_beat(beat_of(MODE_REDIR, 0, 0, 0, 0, 0));
		send_beat(beat_of(MODE_TICK, 0, 0, 1, 0, 0));
		send_beat(beat_of(MODE_TICK, 0, 0, 1, 0, 0));
		send_beat(beat_of(MODE_TICK, 0, 0, 0, 0, 0));
		send_beat(beat_of(MODE_TICK, 0, 0, 1, 0, 0));
		send_beat(beat_of(MODE_TICK, 0, 0, 1, 0, 0));
		send_beat(beat_of(MODE_TICK, 0, 0, 0, 1, 0));
		send_beat(beat_of(MODE_CLEAR, 0, 0, 0, 0, 0));
		send_beat(beat_of(MODE_BRESET, 5, 0, 0, 0, 1));
		send_beat(beat_of(MODE_BRESET, 5, 0, 0, 0, 0));
		send_beat(beat_of(MODE_REDIR, 5, 0, 0, 0, 0));
		send_beat(beat_of(MODE_TICK, 13, 0, 1, 0, 0));
		send_beat(beat_of(MODE_TICK, 15, 1, 1, 0, 0));
		send_beat(beat_of(MODE_BRESET, 15, 1, 0, 0, 0));
	endtask

	// full-scale step into the ceiling, short blank, low voltage, zero step
	task automatic test_limits();
		load_settings('{step_size: 16'd65535, strobe_ticks: 7'd3, current_low: 16'd100,
			current_high: 16'd60000, min_current: 16'd200, note_led_enable: 1'b1,
			default_level: 16'd65535, remember_enable: 1'b0});
		send_beat(beat_of(MODE_CLEAR, 2, 0, 0, 0, 0));
		send_beat(beat_of(MODE_TICK, 2, 0, 1, 0, 0));
		send_beat(beat_of(MODE_TICK, 2, 0, 1, 0, 0));
		send_beat(beat_of(MODE_TICK, 2, 0, 1, 1, 0));
		send_beat(beat_of(MODE_TICK, 2, 0, 1, 1, 0));
		send_beat(beat_of(MODE_TICK, 2, 0, 1, 0, 0));
		send_beat(beat_of(MODE_REDIR, 2, 0, 1, 0, 0));
		send_beat(beat_of(MODE_TICK, 2, 0, 0, 0, 0));
		send_beat(beat_of(MODE_BRESET, 4, 0, 0, 0, 0));
		load_settings('{step_size: 16'd0, strobe_ticks: 7'd1, current_low: 16'd0,
			current_high: 16'd65535, min_current: 16'd0, note_led_enable: 1'b1,
			default_level: 16'd0, remember_enable: 1'b1});
		send_beat(beat_of(MODE_TICK, 4, 0, 1, 0, 0));
		send_beat(beat_of(MODE_TICK, 9, 0, 1, 0, 0));
		send_beat(beat_of(MODE_TICK, 9, 0, 0, 0, 0));
	endtask

	// receiver holds off while the sender keeps offering, so the input backs up
	task automatic test_backpressure();
		hold_asks++;
		gapless = 1'b1;
		for (int k = 0; k < 30; k++) send_beat(random_item());
		gapless = 1'b0;
	endtask

	// random ramp sessions under extreme and random register settings
	task automatic test_random_ramps();
		lbrc_cfg_regs_t s;
		int sent;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: s = '{step_size: 16'd65535, strobe_ticks: 7'd127, current_low: 16'd0,
					current_high: 16'd65535, min_current: 16'd65535, note_led_enable: 1'b1,
					default_level: 16'd65535, remember_enable: 1'b0};
				1: s = '{step_size: 16'd1, strobe_ticks: 7'd0, current_low: 16'd65535,
					current_high: 16'd0, min_current: 16'd0, note_led_enable: 1'b0,
					default_level: 16'd0, remember_enable: 1'b1};
				default: begin
					case ($urandom_range(0, 2))
						0: s.step_size = 16'($urandom_range(1, 400));
						1: s.step_size = 16'($urandom_range(400, 6000));
						default: s.step_size = 16'($urandom_range(6000, 65535));
					endcase
					s.strobe_ticks = ($urandom_range(0, 1) == 1) ? 7'($urandom_range(0, 8)) :
						7'($urandom_range(0, 127));
					s.current_low     = 16'($urandom_range(0, 65535));
					s.current_high    = 16'($urandom_range(0, 65535));
					s.min_current     = 16'($urandom_range(0, 65535));
					s.note_led_enable = 1'($urandom_range(0, 1));
					s.default_level   = 16'($urandom_range(0, 65535));
					s.remember_enable = 1'($urandom_range(0, 1));
				end
			endcase
			load_settings(s);
			sent = 0;
			while (sent < PHASE_BEATS) send_ramp_session(sent);
		end
	endtask

	// result checker: oldest due output against each accepted result beat
	function automatic void cmp_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (due_outputs.size() == 0) begin
				$display("%0t: result beat with nothing due, expected none, actual %p",
					$time, result);
				errors++;
			end else begin
				want_out = due_outputs.pop_front();
				cmp_field("drive_current", want_out.drive_current, result.drive_current);
				cmp_field("flash_on", want_out.flash_on, result.flash_on);
				cmp_field("adjusting", want_out.adjusting, result.adjusting);
				cmp_field("show_direction", want_out.show_direction, result.show_direction);
				cmp_field("direction_down", want_out.direction_down, result.direction_down);
				cmp_field("level", want_out.level, result.level);
			end
		end
	end

	// receiver stall patterns, with the long hold-off counted here
	always @(posedge clk) begin
		if (hold_asks != hold_served) begin
			hold_served++;
			hold_left = HOLD_CYCLES;
		end
		if (stall_left == 0) begin
			stall_kind = stall_kind_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 200);
		end
		stall_left--;
		stall_phase++;
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			case (stall_kind)
				STALL_NONE:     result_stall <= 1'b0;
				STALL_SPARSE:   result_stall <= ($urandom_range(0, 3) == 0);
				STALL_PERIODIC: result_stall <= ((stall_phase % 7) < 3);
				default:        result_stall <= ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	// watchdog on cycles with no beat and no register write
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb_led_brightness_ramp_controller: errors");
				$finish;
			end
		end
	end

	initial begin
		// shadow state after reset
		foreach (lvl_mem[s]) begin
			lvl_mem[s] = '0;
			dir_mem[s] = 1'b0;
		end
		key_latched   = 1'b0;
		limit_pending = 1'b0;
		blank_left    = 0;
		led_lit       = 1'b1;
		cfg = '{step_size: RST_STEP_SIZE, strobe_ticks: RST_STROBE_TICKS,
			current_low: RST_CURRENT_LOW, current_high: RST_CURRENT_HIGH,
			min_current: RST_MIN_CURRENT, note_led_enable: RST_NOTE_LED,
			default_level: RST_DEFAULT_LEVEL, remember_enable: RST_REMEMBER};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basics();
		test_limits();
		test_backpressure();
		test_random_ramps();

		settle();
		repeat (8) @(posedge clk);
		if (due_outputs.size() != 0) begin
			$display("%0t: outputs still due, expected 0, actual %0d", $time,
				due_outputs.size());
			errors++;
		end
		if (errors == 0) begin
			$display("tb_led_brightness_ramp_controller: clean");
		end else begin
			$display("tb_led_brightness_ramp_controller: errors");
		end
		$finish;
	end

endmodule
